FILE: design/pcm_to_one_bit_delta_encoder_top_assert.svh
// ---------------------------------------------------------------------------
// PCM to one-bit delta encoder: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PCM_TO_ONE_BIT_DELTA_ENCODER_TOP_ASSERT_SVH
`define PCM_TO_ONE_BIT_DELTA_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define PCMDE_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pcmde assertion failed");
`define PCMDE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pcmde assertion failed");
`else
`define PCMDE_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define PCMDE_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: design/pcmde_pkg.sv
// ---------------------------------------------------------------------------
// PCM to one-bit delta encoder: package
// Transaction types, format codes and constants shared by the encoder.
// ---------------------------------------------------------------------------
package pcmde_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 6;
    localparam int FORMAT_W = 3;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 3;
    localparam int COUNT_W  = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [FORMAT_W-1:0] FMT_U8_MONO     = 3'd0;
    localparam logic [FORMAT_W-1:0] FMT_U8_STEREO   = 3'd1;
    localparam logic [FORMAT_W-1:0] FMT_S16_MONO    = 3'd2;
    localparam logic [FORMAT_W-1:0] FMT_S16_STEREO  = 3'd3;
    localparam logic [FORMAT_W-1:0] FMT_UNSUPPORTED = 3'd4;

    // word index of the format register (paddr[2])
    localparam logic REG_FORMAT = 1'b0;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 6'd63;
    localparam logic [LEVEL_W-1:0] LEVEL_DEFAULT = 6'd32;

    localparam logic signed [16:0] PCM_OFFSET_MONO   = 17'sd32767;
    localparam logic signed [17:0] PCM_OFFSET_STEREO = 18'sd65534;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_channel;
        logic signed [SAMPLE_W-1:0] second_channel;
        logic                       start_of_sample;
        logic                       final_frame;
    } frame_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  packed_bits;
        logic [COUNT_W-1:0] bits_valid;
        logic [LEVEL_W-1:0] start_level;
        logic               is_start_result;
        logic               last_result;
    } result_t;

endpackage

FILE: design/pcm_to_one_bit_delta_encoder_top.sv
// ---------------------------------------------------------------------------
// PCM to one-bit delta encoder: top level
// Scales frames, steps the 6-bit delta counter and packs direction bits.
// ---------------------------------------------------------------------------
// Path: a frame goes into the input register, then is scaled, stepped and
// written into the result register; a held result stalls both registers.
// Throughput: one frame per cycle while the output is not stalled. Only frames
// that start a sample, complete a byte or are final give a transaction.
// Reset: counter, bit buffer and valids cleared; format = 8-bit mono.
`include "pcm_to_one_bit_delta_encoder_top_assert.svh"

module pcm_to_one_bit_delta_encoder_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               frame_valid,
    output logic                               frame_ready,
    input  pcmde_pkg::frame_t                  frame,
    output logic                               result_valid,
    input  logic                               result_ready,
    output pcmde_pkg::result_t                 result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcmde_pkg::ADDR_W-1:0]       paddr,
    input  logic [pcmde_pkg::DATA_W-1:0]       pwdata,
    output logic [pcmde_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [pcmde_pkg::FORMAT_W-1:0] format_reg;
    logic                           s1_valid_reg, s1_valid_next;
    pcmde_pkg::frame_t              s1_frame_reg;
    logic                           res_valid_reg, res_valid_next;
    pcmde_pkg::result_t             res_reg, res_next;
    logic [pcmde_pkg::LEVEL_W-1:0]  delta_reg, delta_next;
    logic [pcmde_pkg::BYTE_W-1:0]   acc_reg, acc_next;
    logic [pcmde_pkg::POS_W-1:0]    pos_reg, pos_next;

    logic                           s1_advance;
    logic                           s1_fire;
    logic                           cfg_write;
    logic [pcmde_pkg::LEVEL_W-1:0]  level;
    logic                           step_up;
    logic [pcmde_pkg::LEVEL_W-1:0]  delta_step;
    logic [pcmde_pkg::BYTE_W-1:0]   acc_set;
    logic [pcmde_pkg::COUNT_W-1:0]  count;
    logic                           emit_bits;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pcmde_pkg::REG_FORMAT)
                     ? {{(pcmde_pkg::DATA_W-pcmde_pkg::FORMAT_W){1'b0}}, format_reg}
                     : '0;

    // handshake
    assign s1_advance   = !res_valid_reg || result_ready;
    assign frame_ready  = !s1_valid_reg || s1_advance;
    assign s1_fire      = s1_valid_reg && s1_advance;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    pcmde_scale u_scale
    (
        .sample_format  (format_reg),
        .first_channel  (s1_frame_reg.first_channel),
        .second_channel (s1_frame_reg.second_channel),
        .level          (level)
    );

    always_comb
    begin
        if (delta_reg <= level)
        begin
            step_up = (delta_reg != pcmde_pkg::LEVEL_MAX);
        end
        else
        begin
            step_up = (delta_reg == '0);
        end
        delta_step = step_up ? delta_reg + 1'b1 : delta_reg - 1'b1;
        acc_set    = acc_reg | (pcmde_pkg::BYTE_W'(step_up) << pos_reg);
        count      = {1'b0, pos_reg} + 1'b1;
        emit_bits  = count[pcmde_pkg::COUNT_W-1] || s1_frame_reg.final_frame;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        delta_next     = delta_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;

        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (frame_valid && frame_ready)
        begin
            s1_valid_next = 1'b1;
        end

        if (s1_fire)
        begin
            if (s1_frame_reg.start_of_sample)
            begin
                delta_next               = level;
                acc_next                 = '0;
                pos_next                 = '0;
                res_valid_next           = 1'b1;
                res_next.packed_bits     = '0;
                res_next.bits_valid      = '0;
                res_next.start_level     = level;
                res_next.is_start_result = 1'b1;
                res_next.last_result     = s1_frame_reg.final_frame;
            end
            else
            begin
                delta_next = delta_step;
                if (emit_bits)
                begin
                    acc_next                 = '0;
                    pos_next                 = '0;
                    res_valid_next           = 1'b1;
                    res_next.packed_bits     = acc_set;
                    res_next.bits_valid      = count;
                    res_next.start_level     = '0;
                    res_next.is_start_result = 1'b0;
                    res_next.last_result     = s1_frame_reg.final_frame;
                end
                else
                begin
                    acc_next = acc_set;
                    pos_next = count[pcmde_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= pcmde_pkg::FMT_U8_MONO;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            delta_reg     <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_write && paddr[2] == pcmde_pkg::REG_FORMAT)
            begin
                format_reg <= pwdata[pcmde_pkg::FORMAT_W-1:0];
            end
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            delta_reg     <= delta_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            s1_frame_reg <= frame;
        end
        res_reg <= res_next;
    end

    `PCMDE_ASSERT_NOW(a_start_no_bits, clk, rst_n, res_valid_reg && res_reg.is_start_result, res_reg.bits_valid == '0 && res_reg.packed_bits == '0)
    `PCMDE_ASSERT_NOW(a_bits_complete, clk, rst_n, res_valid_reg && !res_reg.is_start_result, res_reg.bits_valid != '0 && (res_reg.bits_valid[3] || res_reg.last_result))
    `PCMDE_ASSERT_NOW(a_acc_clean, clk, rst_n, 1'b1, (acc_reg >> pos_reg) == '0)
    `PCMDE_ASSERT_NEXT(a_start_result, clk, rst_n, s1_fire && s1_frame_reg.start_of_sample, res_valid_reg && res_reg.is_start_result && pos_reg == '0)

endmodule

FILE: design/pcmde_scale.sv
// ---------------------------------------------------------------------------
// PCM to one-bit delta encoder: frame scaler
// Maps one PCM frame to a 0..63 level according to the sample format.
// ---------------------------------------------------------------------------
module pcmde_scale
(
    input  logic [pcmde_pkg::FORMAT_W-1:0]        sample_format,
    input  logic signed [pcmde_pkg::SAMPLE_W-1:0] first_channel,
    input  logic signed [pcmde_pkg::SAMPLE_W-1:0] second_channel,
    output logic [pcmde_pkg::LEVEL_W-1:0]         level
);

    logic [8:0]         u8_sum;
    logic signed [16:0] s16_mono;
    logic signed [17:0] s16_stereo;

    assign u8_sum     = {1'b0, first_channel[7:0]} + {1'b0, second_channel[7:0]};
    assign s16_mono   = {first_channel[15], first_channel} + pcmde_pkg::PCM_OFFSET_MONO;
    assign s16_stereo = {{2{first_channel[15]}}, first_channel}
                      + {{2{second_channel[15]}}, second_channel}
                      + pcmde_pkg::PCM_OFFSET_STEREO;

    always_comb
    begin
        case (sample_format)
            pcmde_pkg::FMT_U8_MONO:    level = first_channel[7:2];
            pcmde_pkg::FMT_U8_STEREO:  level = u8_sum[8:3];
            pcmde_pkg::FMT_S16_MONO:   level = s16_mono[16] ? '0 : s16_mono[15:10];
            pcmde_pkg::FMT_S16_STEREO: level = s16_stereo[17] ? '0 : s16_stereo[16:11];
            default:                   level = pcmde_pkg::LEVEL_DEFAULT;
        endcase
    end

endmodule

FILE: tb/pcm_to_one_bit_delta_encoder_top_tb.sv
// ---------------------------------------------------------------------------
// PCM to one-bit delta encoder: testbench
// Runs directed and random PCM frames through the encoder under every sample
// format. A built-in predictor tracks the delta counter and the bit byte and
// checks each result transaction field by field. Both ends idle at random,
// and the output is held off for a long stretch.
// ---------------------------------------------------------------------------
module pcm_to_one_bit_delta_encoder_top_tb;

    localparam int CLK_PERIOD       = 8;
    localparam int RUN_LIMIT_CYCLES = 400000;
    localparam int PCM_BIAS         = 32767;
    localparam int DRAIN_CYCLES     = 4;
    localparam int PHASE_FRAMES     = 145;
    localparam int HOLD_OFF_CYCLES  = 300;

    // format codes with no package name; encoder treats them as unsupported
    localparam logic [pcmde_pkg::FORMAT_W-1:0] FMT_SPARE5 = 3'd5;
    localparam logic [pcmde_pkg::FORMAT_W-1:0] FMT_SPARE6 = 3'd6;
    localparam logic [pcmde_pkg::FORMAT_W-1:0] FMT_SPARE7 = 3'd7;

    logic                          clk;
    logic                          rst_n;
    logic                          frame_valid;
    logic                          frame_ready;
    pcmde_pkg::frame_t             frame;
    logic                          result_valid;
    logic                          result_ready;
    pcmde_pkg::result_t            result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pcmde_pkg::ADDR_W-1:0]  paddr;
    logic [pcmde_pkg::DATA_W-1:0]  pwdata;
    logic [pcmde_pkg::DATA_W-1:0]  prdata;
    logic                          pready;

    // predictor state
    logic [pcmde_pkg::FORMAT_W-1:0] fmt_now;
    logic [pcmde_pkg::LEVEL_W-1:0]  delta_count;
    logic [pcmde_pkg::BYTE_W-1:0]   bit_byte;
    logic [pcmde_pkg::POS_W-1:0]    bit_pos;
    pcmde_pkg::result_t             due_codes [$];
    pcmde_pkg::result_t             due;

    logic [pcmde_pkg::SAMPLE_W-1:0] wave_a;
    logic [pcmde_pkg::SAMPLE_W-1:0] wave_b;

    bit tx_idle;
    bit rx_idle;
    int stall_left;
    int hold_left;
    int errors;
    int frames_sent;
    int codes_checked;
    int start_codes;
    int format_writes;

    pcm_to_one_bit_delta_encoder_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [pcmde_pkg::LEVEL_W-1:0] frame_level(input pcmde_pkg::frame_t f);
        logic [pcmde_pkg::BYTE_W:0] mix8;
        int sum;
        mix8 = {1'b0, f.first_channel[pcmde_pkg::BYTE_W-1:0]}
             + {1'b0, f.second_channel[pcmde_pkg::BYTE_W-1:0]};
        case (fmt_now)
            pcmde_pkg::FMT_U8_MONO:
                return f.first_channel[7:2];
            pcmde_pkg::FMT_U8_STEREO:
                return mix8[8:3];
            pcmde_pkg::FMT_S16_MONO:
            begin
                sum = int'($signed(f.first_channel)) + PCM_BIAS;
                return (sum < 0) ? '0 : pcmde_pkg::LEVEL_W'(sum >> 10);
            end
            pcmde_pkg::FMT_S16_STEREO:
            begin
                sum = int'($signed(f.first_channel)) + int'($signed(f.second_channel))
                      + 2 * PCM_BIAS;
                return (sum < 0) ? '0 : pcmde_pkg::LEVEL_W'(sum >> 11);
            end
            default:
                return pcmde_pkg::LEVEL_DEFAULT;
        endcase
    endfunction

    // loads the delta counter on a start frame, else steps it; returns 1 when a transaction is due
    function automatic bit delta_encode(input pcmde_pkg::frame_t f,
                                        output pcmde_pkg::result_t r);
        logic [pcmde_pkg::LEVEL_W-1:0] lvl;
        logic                          up;
        logic [pcmde_pkg::COUNT_W-1:0] count;
        lvl = frame_level(f);
        r = '0;
        r.last_result = f.final_frame;
        if (f.start_of_sample)
        begin
            delta_count = lvl;
            bit_byte = '0;
            bit_pos = '0;
            r.start_level = lvl;
            r.is_start_result = 1'b1;
            return 1'b1;
        end
        if (delta_count <= lvl)
            up = (delta_count != pcmde_pkg::LEVEL_MAX);
        else
            up = (delta_count == '0);
        delta_count = up ? delta_count + 1'b1 : delta_count - 1'b1;
        if (up)
            bit_byte[bit_pos] = 1'b1;
        count = {1'b0, bit_pos} + 1'b1;
        bit_pos = count[pcmde_pkg::POS_W-1:0];
        if (count < pcmde_pkg::BYTE_W && !f.final_frame)
            return 1'b0;
        r.packed_bits = bit_byte;
        r.bits_valid = count;
        bit_byte = '0;
        bit_pos = '0;
        return 1'b1;
    endfunction

    function automatic pcmde_pkg::frame_t pcm(input logic [pcmde_pkg::SAMPLE_W-1:0] a,
                                              input logic [pcmde_pkg::SAMPLE_W-1:0] b,
                                              input bit s, input bit f);
        pcmde_pkg::frame_t fr;
        fr.first_channel = a;
        fr.second_channel = b;
        fr.start_of_sample = s;
        fr.final_frame = f;
        return fr;
    endfunction

    function automatic logic [pcmde_pkg::SAMPLE_W-1:0] next_sample(
        input logic [pcmde_pkg::SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 9))
            0: return pcmde_pkg::SAMPLE_W'($urandom);
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'h00FF;
            4: return 16'h0000;
            default: return prev + pcmde_pkg::SAMPLE_W'($urandom_range(0, 128)) - 16'd64;
        endcase
    endfunction

    function automatic pcmde_pkg::frame_t wave_frame(input bit s, input bit f);
        wave_a = next_sample(wave_a);
        wave_b = next_sample(wave_b);
        return pcm(wave_a, wave_b, s, f);
    endfunction

    task automatic send_frame(input pcmde_pkg::frame_t f);
        int gap;
        pcmde_pkg::result_t r;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            frame_valid <= 1'b0;
        end
        @(negedge clk);
        frame_valid <= 1'b1;
        frame <= f;
        do @(posedge clk); while (!frame_ready);
        frames_sent++;
        if (delta_encode(f, r))
            due_codes.push_back(r);
    endtask

    task automatic stop_frames();
        @(negedge clk);
        frame_valid <= 1'b0;
    endtask

    task automatic write_format(input logic [pcmde_pkg::FORMAT_W-1:0] code);
        logic [pcmde_pkg::DATA_W-1:0] word;
        word = $urandom;
        word[pcmde_pkg::FORMAT_W-1:0] = code;
        stop_frames();
        while (due_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {pcmde_pkg::REG_FORMAT, 2'b00};
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        fmt_now = code;
        format_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[pcmde_pkg::FORMAT_W-1:0] !== code)
        begin
            $error("sample_format readback: expected %0d, got %0d", code,
                   prdata[pcmde_pkg::FORMAT_W-1:0]);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // output side: per-transaction stall, plus an optional long hold-off
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            codes_checked++;
            if (due_codes.size() == 0)
            begin
                $error("unexpected transaction: packed_bits %0h bits_valid %0d start_level %0d",
                       result.packed_bits, result.bits_valid, result.start_level);
                errors++;
            end
            else
            begin
                due = due_codes.pop_front();
                if (due.is_start_result)
                    start_codes++;
                if (result.packed_bits !== due.packed_bits)
                begin
                    $error("packed_bits: expected %0h, got %0h", due.packed_bits,
                           result.packed_bits);
                    errors++;
                end
                if (result.bits_valid !== due.bits_valid)
                begin
                    $error("bits_valid: expected %0d, got %0d", due.bits_valid,
                           result.bits_valid);
                    errors++;
                end
                if (result.start_level !== due.start_level)
                begin
                    $error("start_level: expected %0d, got %0d", due.start_level,
                           result.start_level);
                    errors++;
                end
                if (result.is_start_result !== due.is_start_result)
                begin
                    $error("is_start_result: expected %0b, got %0b", due.is_start_result,
                           result.is_start_result);
                    errors++;
                end
                if (result.last_result !== due.last_result)
                begin
                    $error("last_result: expected %0b, got %0b", due.last_result,
                           result.last_result);
                    errors++;
                end
            end
            if (rx_idle)
                stall_left = $urandom_range(0, 5);
        end
    end

    // counter steps from zero after reset, with out-of-range 8-bit values
    task automatic test_before_start();
        send_frame(pcm(16'h00FF, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'hFF03, 16'hFFFF, 1'b0, 1'b0));
        send_frame(pcm(16'h0080, 16'h8000, 1'b0, 1'b1));
    endtask

    // counter reverses at 63 and at 0
    task automatic test_turnaround();
        send_frame(pcm(16'h00FF, 16'h0000, 1'b1, 1'b0));
        send_frame(pcm(16'h00FF, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'h00FF, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'h0000, 16'h0000, 1'b0, 1'b1));
        send_frame(pcm(16'h0000, 16'h0000, 1'b1, 1'b0));
        send_frame(pcm(16'h0000, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'h0000, 16'h0000, 1'b0, 1'b1));
    endtask

    // a new start drops a partly filled byte; start and final on one frame
    task automatic test_partial_discard();
        send_frame(pcm(16'h0040, 16'h0000, 1'b1, 1'b0));
        send_frame(pcm(16'h00C0, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'h0000, 16'h0000, 1'b0, 1'b0));
        send_frame(pcm(16'h00C0, 16'h0000, 1'b1, 1'b1));
        send_frame(pcm(16'h00FF, 16'h0000, 1'b0, 1'b1));
    endtask

    task automatic test_format_extremes();
        write_format(pcmde_pkg::FMT_U8_STEREO);
        send_frame(pcm(16'h00FF, 16'hFF00, 1'b1, 1'b0));
        send_frame(pcm(16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
        write_format(pcmde_pkg::FMT_S16_MONO);
        send_frame(pcm(16'h8000, 16'h7FFF, 1'b1, 1'b0));
        send_frame(pcm(16'h7FFF, 16'h8000, 1'b0, 1'b1));
        write_format(pcmde_pkg::FMT_S16_STEREO);
        send_frame(pcm(16'h8000, 16'h8000, 1'b1, 1'b0));
        send_frame(pcm(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_frame(pcm(16'h8001, 16'h8001, 1'b0, 1'b1));
        write_format(pcmde_pkg::FMT_UNSUPPORTED);
        send_frame(pcm(pcmde_pkg::SAMPLE_W'($urandom), pcmde_pkg::SAMPLE_W'($urandom),
                       1'b1, 1'b1));
        write_format(FMT_SPARE7);
        send_frame(pcm(pcmde_pkg::SAMPLE_W'($urandom), pcmde_pkg::SAMPLE_W'($urandom),
                       1'b1, 1'b0));
        send_frame(pcm(pcmde_pkg::SAMPLE_W'($urandom), pcmde_pkg::SAMPLE_W'($urandom),
                       1'b0, 1'b1));
    endtask

    task automatic test_random_streams();
        logic [pcmde_pkg::FORMAT_W-1:0] plan [12];
        int phase_start;
        int len;
        plan = '{pcmde_pkg::FMT_U8_MONO, pcmde_pkg::FMT_U8_STEREO,
                 pcmde_pkg::FMT_S16_MONO, pcmde_pkg::FMT_S16_STEREO,
                 pcmde_pkg::FMT_UNSUPPORTED, FMT_SPARE5, FMT_SPARE6, FMT_SPARE7,
                 pcmde_pkg::FMT_S16_STEREO, pcmde_pkg::FMT_U8_MONO,
                 pcmde_pkg::FMT_S16_MONO, pcmde_pkg::FMT_U8_STEREO};
        for (int i = 0; i < 12; i++)
        begin
            write_format(plan[i]);
            tx_idle = i[0];
            rx_idle = i[1];
            phase_start = frames_sent;
            while (frames_sent - phase_start < PHASE_FRAMES)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_frame(pcmde_pkg::frame_t'({$urandom, $urandom}));
                else
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 17);
                    send_frame(wave_frame(1'b1, len == 0));
                    for (int k = 1; k <= len; k++)
                        send_frame(wave_frame(1'b0, k == len));
                end
            end
        end
    endtask

    // output held off while frames keep coming, so the encoder backs up
    task automatic test_output_stall();
        write_format(pcmde_pkg::FMT_S16_MONO);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        for (int k = 0; k < 80; k++)
            send_frame(wave_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        rst_n = 1'b0;
        frame_valid = 1'b0;
        frame = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fmt_now = pcmde_pkg::FMT_U8_MONO;
        delta_count = '0;
        bit_byte = '0;
        bit_pos = '0;
        wave_a = '0;
        wave_b = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        stall_left = 0;
        hold_left = 0;
        errors = 0;
        frames_sent = 0;
        codes_checked = 0;
        start_codes = 0;
        format_writes = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_before_start();
        test_turnaround();
        test_partial_discard();
        test_format_extremes();
        test_random_streams();
        test_output_stall();

        stop_frames();
        while (due_codes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Sent %0d frames over %0d format writes (all eight codes), held output %0d cycles",
                 frames_sent, format_writes, HOLD_OFF_CYCLES);
        $display("Checked %0d transactions, %0d of them start levels", codes_checked,
                 start_codes);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/pcmde_pkg.sv
design/pcmde_scale.sv
design/pcm_to_one_bit_delta_encoder_top.sv
tb/pcm_to_one_bit_delta_encoder_top_tb.sv
